// File: rtl/bfa_pkg.sv
package bfa_pkg;

  // Default geometry: frames tracked and bytes per frame as a shift
  localparam int unsigned MAX_FRAMES_DEF  = 32768;
  localparam int unsigned FRAME_SHIFT_DEF = 12;

  // Configuration register file
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned TOTAL_RST    = 32768;
  localparam int unsigned RESERVED_RST = 512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_e;

endpackage

// File: rtl/bitmap_frame_allocator.sv
// Bitmap frame allocator, first fit, one bit per frame (1 = used).
//
// Channels: the input word carries operation_i (allocate, free, reinit, nop)
// and address_i (byte address, used by free). Each input word yields exactly
// one result word: frame_address_o, out_of_memory_o and free_count_o. Both
// channels use valid/ready. The config port (cfg_we_i, cfg_idx_i, cfg_data_i)
// writes the frame total (index 0) or the reserved boundary (index 1).
// Steps: allocate reads the bitmap RAM one word per cycle, stops at the first
// word that is not full and then sets the frame's bit if it is below the
// total; reinit writes one RAM word per cycle; free reads the word and writes
// it back, or skips the write when the frame is out of range; nop goes
// straight to the result.
// One item is in flight at a time; in_ready_o is high only while idle, so
// the next input word waits until the sequencer is done with the last one.
// Reset: a sweep writes the reset map word by word (frames below 512 used,
// the rest up to the total free); no input word is taken meanwhile.
// A finished result sits in the output register; the next input word is
// still accepted while it waits. If the receiver stalls, the following
// result holds in the sequencer until the output register frees up.
module bitmap_frame_allocator #(
  parameter int unsigned MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [31:0]                   address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   frame_address_o,
  output logic                          out_of_memory_o,
  output logic [15:0]                   free_count_o
);
  import bfa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + 31) / 32;
  localparam int unsigned WW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned FW   = $clog2(MAX_FRAMES + 1);   // frame count width
  localparam int unsigned IW   = FW - 5;                   // word part of a frame
  localparam int unsigned XW   = (FW > CFG_W) ? FW + 1 : CFG_W + 1;
  localparam int unsigned FAW  = 32 - FRAME_SHIFT;
  localparam int unsigned FX   = (FAW > FW) ? FAW : FW;
  localparam int unsigned RTOP = (TOTAL_RST > MAX_FRAMES) ? MAX_FRAMES : TOTAL_RST;
  localparam int unsigned RRES = (RESERVED_RST > MAX_FRAMES) ? MAX_FRAMES : RESERVED_RST;
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

  // Configuration registers
  logic [CFG_W-1:0] total_q, reserved_q;

  // Sequencer and control
  state_e          state_q, state_d;
  logic [WW-1:0]   wcnt_q;
  logic            issue_done_q;
  logic            pend_q;
  logic [FW-1:0]   init_top_q, init_res_q;
  logic            init_reply_q;
  logic [FW-1:0]   cnt_q;
  logic            out_valid_q;

  // Payload registers
  logic [WW-1:0]   pidx_q;
  logic [31:0]     word_q;
  logic [4:0]      bit_q;
  logic [FX-1:0]   fidx_q;
  logic [31:0]     res_addr_q;
  logic            res_oom_q;

  // Bitmap memory
  logic [31:0]     mem [MAP_WORDS];
  logic [31:0]     rdata_q;
  logic            mem_we;
  logic [WW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata;

  // Datapath
  logic            accept, slot_free;
  logic [XW-1:0]   tot_ext, res_ext;
  logic [FW-1:0]   top_c, res_c;
  logic [IW-1:0]   w_ext;
  logic [31:0]     ge_mask, lt_mask, init_word;
  logic [FW-1:0]   init_count;
  logic            found, exhaust;
  logic [4:0]      low_zero;
  logic [FW-1:0]   alloc_frame;
  logic            alloc_ok;
  logic [63:0]     alloc_addr;
  logic            free_ok;
  logic [WW-1:0]   free_word;
  logic [FW+15:0]  cnt_x;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // Clamp register values to the map size
  assign tot_ext = XW'(total_q);
  assign res_ext = XW'(reserved_q);
  assign top_c   = (tot_ext > XW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(tot_ext);
  assign res_c   = (res_ext > XW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(res_ext);

  // Reinit word: bit free where reserved <= frame < total
  assign w_ext = IW'(wcnt_q);
  always_comb begin
    if (w_ext > init_res_q[FW-1:5]) begin
      ge_mask = '1;
    end else if (w_ext == init_res_q[FW-1:5]) begin
      ge_mask = 32'hFFFF_FFFF << init_res_q[4:0];
    end else begin
      ge_mask = '0;
    end
    if (w_ext < init_top_q[FW-1:5]) begin
      lt_mask = '1;
    end else if (w_ext == init_top_q[FW-1:5]) begin
      lt_mask = ~(32'hFFFF_FFFF << init_top_q[4:0]);
    end else begin
      lt_mask = '0;
    end
  end
  assign init_word  = ~(ge_mask & lt_mask);
  assign init_count = (init_top_q > init_res_q) ? init_top_q - init_res_q : '0;

  // Scan: RAM data of the previously issued word
  assign found   = pend_q && (rdata_q != 32'hFFFF_FFFF);
  assign exhaust = pend_q && (pidx_q == LAST_WORD) && !found;

  always_comb begin
    low_zero = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (!rdata_q[b]) begin
        low_zero = 5'(b);
      end
    end
  end

  assign alloc_frame = FW'({pidx_q, bit_q});
  assign alloc_ok    = alloc_frame < top_c;
  assign alloc_addr  = 64'(alloc_frame) << FRAME_SHIFT;

  assign free_ok   = fidx_q < FX'(top_c);
  assign free_word = fidx_q[WW+4:5];

  assign cnt_x = (FW + 16)'(cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (wcnt_q == LAST_WORD) begin
          state_d = init_reply_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(operation_i))
            OP_ALLOC: state_d = ST_SCAN;
            OP_FREE:  state_d = ST_FREE_RD;
            OP_INIT:  state_d = ST_INIT;
            OP_NOP:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_ALLOC;
        end else if (exhaust) begin
          state_d = ST_DONE;
        end
      end
      ST_ALLOC:   state_d = ST_DONE;
      ST_FREE_RD: state_d = free_ok ? ST_FREE_WR : ST_DONE;
      ST_FREE_WR: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM port and input handshake
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wcnt_q;
    mem_wdata  = init_word;
    mem_raddr  = wcnt_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SCAN: begin
      end
      ST_ALLOC: begin
        mem_we    = alloc_ok;
        mem_waddr = pidx_q;
        mem_wdata = word_q | (32'd1 << bit_q);
      end
      ST_FREE_RD: begin
        mem_raddr = free_word;
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = free_word;
        mem_wdata = rdata_q & ~(32'd1 << fidx_q[4:0]);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Bitmap RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= CFG_W'(TOTAL_RST);
      reserved_q <= CFG_W'(RESERVED_RST);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TOTAL:    total_q    <= cfg_data_i;
        REG_RESERVED: reserved_q <= cfg_data_i;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      wcnt_q       <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      init_top_q   <= FW'(RTOP);
      init_res_q   <= FW'(RRES);
      init_reply_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load the output register as the finished result leaves the sequencer;
      // drop valid once the receiver takes the word.
      if ((state_q == ST_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        wcnt_q       <= '0;
        issue_done_q <= 1'b0;
        pend_q       <= 1'b0;
        init_reply_q <= (op_e'(operation_i) == OP_INIT);
        if (op_e'(operation_i) == OP_INIT) begin
          init_top_q <= top_c;
          init_res_q <= res_c;
        end
      end
      unique case (state_q)
        ST_INIT: begin
          wcnt_q <= wcnt_q + WW'(1);
          if (wcnt_q == LAST_WORD) begin
            cnt_q <= init_count;
          end
        end
        ST_SCAN: begin
          if (!found) begin
            pend_q <= !issue_done_q;
            if (!issue_done_q) begin
              wcnt_q       <= wcnt_q + WW'(1);
              issue_done_q <= (wcnt_q == LAST_WORD);
            end
          end
        end
        ST_ALLOC: begin
          if (alloc_ok && (cnt_q != '0)) begin
            cnt_q <= cnt_q - FW'(1);
          end
        end
        ST_FREE_WR: begin
          if (cnt_q < FW'(MAX_FRAMES)) begin
            cnt_q <= cnt_q + FW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fidx_q     <= FX'(address_i >> FRAME_SHIFT);
      res_addr_q <= '0;
      res_oom_q  <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (found) begin
        word_q <= rdata_q;
        bit_q  <= low_zero;
      end else begin
        pidx_q <= wcnt_q;
      end
      if (exhaust) begin
        res_oom_q <= 1'b1;
      end
    end
    if (state_q == ST_ALLOC) begin
      if (alloc_ok) begin
        res_addr_q <= alloc_addr[31:0];
      end else begin
        res_oom_q <= 1'b1;
      end
    end
    if ((state_q == ST_DONE) && slot_free) begin
      frame_address_o <= res_addr_q;
      out_of_memory_o <= res_oom_q;
      free_count_o    <= cnt_x[15:0];
    end
  end

  assign out_valid_o = out_valid_q;

  // A failed allocate never reports an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_memory_o) |-> (frame_address_o == 32'd0))
    else $error("out_of_memory with nonzero frame address");

  // The free count stays within the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FW'(MAX_FRAMES))
    else $error("free count above map size");

  // An accepted word starts work; the block drops ready next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready held after accept");

  // A scan that runs off the last word reports out of memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && exhaust) |=> (state_q == ST_DONE && res_oom_q))
    else $error("exhausted scan did not flag out of memory");

endmodule

// File: verif/tb_bitmap_frame_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int unsigned MAX_FRAMES  = MAX_FRAMES_DEF;
  localparam int unsigned FRAME_SHIFT = FRAME_SHIFT_DEF;
  localparam int unsigned WORDS       = MAX_FRAMES / 32;
  // Longest legal silence is one full bitmap scan plus receiver stalls;
  // allow many times that before calling the run hung.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned BURST       = 46;

  typedef struct packed {
    op_e         op;
    logic [31:0] addr;
  } request_t;

  typedef struct packed {
    logic [31:0] frame_address;
    logic        out_of_memory;
    logic [15:0] free_count;
  } grant_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_TOTAL;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           operation_i = OP_NOP;
  logic [31:0]          address_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [31:0]          frame_address_o;
  logic                 out_of_memory_o;
  logic [15:0]          free_count_o;

  bitmap_frame_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_address_o(frame_address_o),
    .out_of_memory_o(out_of_memory_o),
    .free_count_o   (free_count_o)
  );

  // Requests waiting for the driver, and grants the allocator still owes us.
  request_t    request_q[$];
  grant_t      grant_q[$];
  request_t    next_request;
  grant_t      owed;
  bit          failed = 1'b0;
  bit          steady = 1'b0;

  // Shadow of the allocator: registers, bitmap (1 = used) and free count.
  logic [15:0] total_cfg;
  logic [15:0] reserved_cfg;
  logic [31:0] used_map [WORDS];
  int unsigned spare_count;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_frames(int unsigned v);
    return (v > MAX_FRAMES) ? MAX_FRAMES : v;
  endfunction

  // Mark everything used, then hand back the frames between the reserved
  // boundary and the total.
  function automatic void reload_map();
    int unsigned top;
    top = clamp_frames(total_cfg);
    foreach (used_map[w]) used_map[w] = '1;
    spare_count = 0;
    for (int unsigned f = clamp_frames(reserved_cfg); f < top; f++) begin
      used_map[f / 32][f % 32] = 1'b0;
      spare_count++;
    end
  endfunction

  // Apply one request to the shadow and return the grant it must produce.
  function automatic grant_t serve_request(op_e op, logic [31:0] addr);
    grant_t      g;
    int unsigned top;
    int unsigned f;
    bit          hit;
    g   = '0;
    top = clamp_frames(total_cfg);
    hit = 1'b0;
    case (op)
      OP_ALLOC: begin
        g.out_of_memory = 1'b1;
        // First fit: skip full words, stop at the lowest clear bit. A clear
        // bit at or above the total ends the search with no frame.
        for (int w = 0; w < WORDS && !hit; w++) begin
          if (used_map[w] != '1) begin
            for (int b = 0; b < 32 && !hit; b++) begin
              if (!used_map[w][b]) begin
                hit = 1'b1;
                f   = w * 32 + b;
                if (f < top) begin
                  used_map[w][b]  = 1'b1;
                  if (spare_count != 0) spare_count--;
                  g.frame_address = f << FRAME_SHIFT;
                  g.out_of_memory = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_FREE: begin
        // Drop the offset bits; ignore frames past the total. A double free
        // still bumps the count, up to the saturation point.
        f = addr >> FRAME_SHIFT;
        if (f < top) begin
          used_map[f / 32][f % 32] = 1'b0;
          if (spare_count < MAX_FRAMES) spare_count++;
        end
      end
      OP_INIT: begin
        reload_map();
      end
      default: begin
      end
    endcase
    g.free_count = spare_count[15:0];
    return g;
  endfunction

  // Driver: present the next request when the slot is empty or the current
  // word is being taken; hold valid and payload otherwise.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= OP_NOP;
      address_i   <= '0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 35);
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
          next_request = request_q.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= next_request.op;
          address_i   <= next_request.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the outgoing grant first, then track register writes,
  // then predict for the request word taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result word: addr %h oom %b count %0d", $time,
                   frame_address_o, out_of_memory_o, free_count_o);
          failed = 1'b1;
        end else begin
          owed = grant_q.pop_front();
          if (frame_address_o !== owed.frame_address) begin
            $display("%0t: frame_address expected %h, got %h", $time,
                     owed.frame_address, frame_address_o);
            failed = 1'b1;
          end
          if (out_of_memory_o !== owed.out_of_memory) begin
            $display("%0t: out_of_memory expected %b, got %b", $time,
                     owed.out_of_memory, out_of_memory_o);
            failed = 1'b1;
          end
          if (free_count_o !== owed.free_count) begin
            $display("%0t: free_count expected %0d, got %0d", $time,
                     owed.free_count, free_count_o);
            failed = 1'b1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TOTAL) begin
          total_cfg = cfg_data_i;
        end else begin
          reserved_cfg = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_o) begin
        grant_q.push_back(serve_request(op_e'(operation_i), address_i));
      end
    end
  end

  // Watchdog: end the run when no word moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_op(input op_e op, input logic [31:0] addr);
    request_q.push_back('{op: op, addr: addr});
  endtask

  // Wait until every request went out and every grant came back. Sample on
  // the falling edge so the driver's updates have settled.
  task automatic settle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || grant_q.size() != 0);
  endtask

  task automatic set_regs(input logic [15:0] tot, input logic [15:0] res);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TOTAL;
    cfg_data_i <= tot;
    @(posedge clk_i);
    cfg_idx_i  <= REG_RESERVED;
    cfg_data_i <= res;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly allocations and frees around the boundary where frames get
  // handed out, so small maps run dry and refill; a few stray addresses,
  // reinits and no-ops mixed in.
  task automatic random_burst(input int unsigned res, input bit fresh,
                              input int unsigned alloc_pct);
    int unsigned roll;
    int unsigned lo;
    int unsigned frame;
    logic [31:0] addr;
    lo = clamp_frames(res);
    lo = (lo > 8) ? lo - 8 : 0;
    if (fresh) queue_op(OP_INIT, $urandom());
    for (int i = fresh; i < BURST; i++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        queue_op(OP_ALLOC, $urandom());
      end else if (roll < alloc_pct + 4) begin
        queue_op(OP_INIT, $urandom());
      end else if (roll < alloc_pct + 8) begin
        queue_op(OP_NOP, $urandom());
      end else if (roll < alloc_pct + 14) begin
        queue_op(OP_FREE, $urandom());
      end else begin
        frame = lo + $urandom_range(0, 96);
        addr  = frame << FRAME_SHIFT;
        if ($urandom_range(3) == 0) addr[FRAME_SHIFT-1:0] = FRAME_SHIFT'($urandom());
        queue_op(OP_FREE, addr);
      end
    end
  endtask

  initial begin
    int unsigned tot;
    int unsigned res;
    total_cfg    = TOTAL_RST;
    reserved_cfg = RESERVED_RST;
    reload_map();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold off until the reset sweep has written the bitmap.
    do @(negedge clk_i);
    while (!in_ready_o);

    // Default map: first fit past the reserved area, double free, unaligned
    // and out-of-range frees, no-op, reinit.
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '1);
    queue_op(OP_FREE, 32'(513) << FRAME_SHIFT);
    queue_op(OP_FREE, 32'(513) << FRAME_SHIFT);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, (32'(512) << FRAME_SHIFT) | 32'hABC);
    queue_op(OP_FREE, 32'(MAX_FRAMES) << FRAME_SHIFT);
    queue_op(OP_FREE, 32'hFFFF_FFFF);
    queue_op(OP_NOP, 32'h5A5A_A5A5);
    queue_op(OP_INIT, '0);
    settle();

    // Oversized total clamps; no reserve gives frame zero and a full count
    // that saturates on frees of free frames.
    set_regs(16'hFFFF, 16'd0);
    queue_op(OP_INIT, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, '0);
    queue_op(OP_FREE, '0);
    settle();

    // Two free frames: drain them, then run out with the count at zero.
    set_regs(16'd10, 16'd8);
    queue_op(OP_INIT, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    settle();

    // Reserve above total: nothing freed.
    set_regs(16'd10, 16'd20);
    queue_op(OP_INIT, '0);
    queue_op(OP_ALLOC, '0);
    settle();

    set_regs(16'd10, 16'd0);
    queue_op(OP_INIT, '0);
    settle();

    // Shrink the total without reinit: free frames above it stay unreachable.
    set_regs(16'd3, 16'd0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, 32'(5) << FRAME_SHIFT);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    settle();

    // Random phases over a spread of geometries, extremes included; two of
    // them keep the old map after the register change.
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          tot = 64;
          res = 16;
        end
        1: begin
          tot = 16'hFFFF;
          res = 16'hFFFF;
        end
        2: begin
          tot = 0;
          res = 0;
        end
        3: begin
          tot = 48;
          res = 0;
        end
        5: begin
          tot = MAX_FRAMES;
          res = MAX_FRAMES - 68;
        end
        7: begin
          tot = 100;
          res = 37;
        end
        8: begin
          tot = MAX_FRAMES;
          res = 0;
        end
        11: begin
          tot = 16'($urandom());
          res = 16'($urandom());
        end
        default: begin
          tot = $urandom_range(1, 160);
          res = $urandom_range(0, tot + 8);
        end
      endcase
      settle();
      // Phase six runs with no idling on either side.
      steady = (p == 6);
      set_regs(16'(tot), 16'(res));
      random_burst(res, (p != 6) && (p != 9), 35 + $urandom_range(0, 40));
    end

    settle();
    steady = 1'b0;
    // Give a stray late word a full scan's time to show up.
    repeat (WORDS + 8) @(posedge clk_i);
    if (!failed && grant_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: bitmap_frame_allocator.f
rtl/bfa_pkg.sv
rtl/bitmap_frame_allocator.sv
verif/tb_bitmap_frame_allocator.sv
